// ----- design/spq_pkg.sv -----
package spq_pkg;

  // Queue geometry
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int PRIO_W  = 8;
  localparam int COUNT_W = 5;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored entry of the sorted chain
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } spq_entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } spq_ctrl_t;

endpackage

// ----- design/spq_if.sv -----
interface spq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [spq_pkg::DATA_W-1:0]   data_value;
  logic [spq_pkg::PRIO_W-1:0]   priority_req;

  modport source (output valid, command, data_value, priority_req, input ready);
  modport sink   (input valid, command, data_value, priority_req, output ready);
endinterface

interface spq_out_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::DATA_W-1:0]   data_out;
  logic                         data_valid;
  logic [1:0]                   status;
  logic [spq_pkg::COUNT_W-1:0]  entry_count;
  logic                         queue_empty;

  modport source (output valid, data_out, data_valid, status, entry_count, queue_empty,
                  input ready);
  modport sink   (input valid, data_out, data_valid, status, entry_count, queue_empty,
                  output ready);
endinterface

// ----- design/stable_priority_queue_core.sv -----
// Stable priority queue of spq_pkg::DEPTH entries held as a sorted chain of cells,
// head in cell 0. Each item is an enqueue or a dequeue and yields one result in the
// cycle after it is accepted; every cell compares its own priority with the new
// one in parallel and shifts by one place, so an item is accepted every cycle
// while the result register is free or being drained. Equal priorities leave in
// arrival order. Enqueue into a full queue reports full and changes nothing;
// dequeue from an empty queue reports empty.
module stable_priority_queue_core (
  input  logic             clk,
  input  logic             rst_n,
  spq_in_if.sink           in_ch,
  spq_out_if.source        out_ch
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int CNT_W = spq_pkg::CNT_W;

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                accept;
  logic                is_enq;
  logic                full;
  logic                empty;
  spq_pkg::spq_ctrl_t  ctrl;

  logic                        out_valid_r;
  logic [spq_pkg::DATA_W-1:0]  out_data_r;
  logic                        out_dvalid_r;
  spq_pkg::status_t            out_status_r;
  logic [spq_pkg::COUNT_W-1:0] out_count_r;
  logic                        out_empty_r;

  spq_pkg::spq_entry_t         entries [DEPTH];
  logic [DEPTH-1:0]            gbs;
  logic [spq_pkg::EXT_W-1:0]   cnt_ext;
  spq_pkg::status_t            status_nxt;

  // Accept while the result register is free or being taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_enq      = (in_ch.command == spq_pkg::CMD_ENQ);
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);

  assign ctrl.enq  = accept && is_enq && !full;
  assign ctrl.deq  = accept && !is_enq && !empty;
  assign ctrl.prio = in_ch.priority_req;
  assign ctrl.data = in_ch.data_value;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                valid_i;
    logic                left_gb_i;
    spq_pkg::spq_entry_t left_i;
    spq_pkg::spq_entry_t right_i;

    assign valid_i = (count_r > CNT_W'(i));
    if (i == 0) begin : g_head
      assign left_gb_i = 1'b0;
      assign left_i    = entries[0];
    end else begin : g_body
      assign left_gb_i = gbs[i-1];
      assign left_i    = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_i = entries[i];
    end else begin : g_mid
      assign right_i = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (valid_i),
      .left_gb    (left_gb_i),
      .left_entry (left_i),
      .right_entry(right_i),
      .gb         (gbs[i]),
      .entry      (entries[i])
    );
  end

  // Occupancy and status
  always_comb begin
    count_nxt = count_r;
    if (ctrl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (is_enq) begin
      status_nxt = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
    end else begin
      status_nxt = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
    end
  end

  assign cnt_ext = spq_pkg::EXT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= ctrl.deq ? entries[0].data : '0;
      out_dvalid_r <= ctrl.deq;
      out_status_r <= status_nxt;
      out_count_r  <= cnt_ext[spq_pkg::COUNT_W-1:0];
      out_empty_r  <= (count_nxt == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.data_valid  = out_dvalid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.queue_empty = out_empty_r;

endmodule

// ----- design/spq_cell.sv -----
module spq_cell (
  input  logic                clk,
  input  spq_pkg::spq_ctrl_t  ctrl,
  input  logic                valid,
  input  logic                left_gb,
  input  spq_pkg::spq_entry_t left_entry,
  input  spq_pkg::spq_entry_t right_entry,
  output logic                gb,
  output spq_pkg::spq_entry_t entry
);

  spq_pkg::spq_entry_t entry_r;
  spq_pkg::spq_entry_t entry_nxt;

  // New item belongs at or before this slot: slot empty or strictly lower priority
  assign gb = !valid || (entry_r.prio < ctrl.prio);
  assign entry = entry_r;

  // Hold, shift right, take new item, or shift left on removal
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.enq && gb) begin
      if (left_gb) begin
        entry_nxt = left_entry;
      end else begin
        entry_nxt.prio = ctrl.prio;
        entry_nxt.data = ctrl.data;
      end
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- design/spq_checker.sv -----
module spq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [spq_pkg::DATA_W-1:0]  out_data_out,
  input logic                        out_data_valid,
  input logic [1:0]                  out_status,
  input logic [spq_pkg::COUNT_W-1:0] out_entry_count,
  input logic                        out_queue_empty
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out) && $stable(out_status))
    else $error("result changed while stalled");

  // Empty queue reports a zero count
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_empty |-> out_entry_count == '0)
    else $error("empty flag with nonzero count");

  // Dequeued word only with ok status, otherwise data is zero
  a_dvalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data_valid ? (out_status == spq_pkg::ST_OK) : (out_data_out == '0)))
    else $error("data_valid inconsistent with status or data");

  // Empty dequeue leaves an empty queue, full enqueue a nonempty one
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == spq_pkg::ST_EMPTY || out_status == spq_pkg::ST_FULL)
    |-> (out_queue_empty == (out_status == spq_pkg::ST_EMPTY)) && !out_data_valid)
    else $error("error status inconsistent with queue state");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_data_out   (out_ch.data_out),
  .out_data_valid (out_ch.data_valid),
  .out_status     (out_ch.status),
  .out_entry_count(out_ch.entry_count),
  .out_queue_empty(out_ch.queue_empty)
);
